>>> rtl/core/oaht_pkg.sv
// ----------------------------------------------------------------------------
// Open-address hash table package
// Shared constants, command codes and slot status codes of the hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package oaht_pkg;

   localparam int SLOT_INDEX_BITS_DEFAULT = 10;
   localparam int KEY_BITS_DEFAULT        = 32;
   localparam int VALUE_BITS_DEFAULT      = 32;

   localparam int CMD_W      = 2;
   localparam int KEY_W      = 32;
   localparam int HASH_W     = 64;
   localparam int VALUE_W    = 32;
   localparam int OCCUPIED_W = 11;
   localparam int SIZE_W     = 4;
   localparam int STATUS_W   = 2;

   localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET = 4'd10;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_status_type;

endpackage

`default_nettype wire

>>> rtl/core/open_address_hash_table_core.sv
// ----------------------------------------------------------------------------
// Open-address hash table core
// Key-value table in slot memory with triangular probing, one probe a cycle.
// ----------------------------------------------------------------------------
// A request (insert, lookup, remove or clear) is taken only while the core is
// idle. Insert, lookup and remove walk the probe sequence through one slot
// memory, reading one slot per cycle, so such a request occupies the core for
// its whole walk. A clear sweeps every slot of the memory, one per cycle. After
// reset the same sweep runs before the first request is accepted; the size
// register can be written whenever the core is idle, and a pending size write
// holds off a request for that cycle. A finished response word waits in an
// output register, so the next request is accepted while it is still held.
// ----------------------------------------------------------------------------
`default_nettype none

module open_address_hash_table_core #(
   parameter int SLOT_INDEX_BITS = oaht_pkg::SLOT_INDEX_BITS_DEFAULT,
   parameter int KEY_BITS        = oaht_pkg::KEY_BITS_DEFAULT,
   parameter int VALUE_BITS      = oaht_pkg::VALUE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [oaht_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [oaht_pkg::KEY_W-1:0]        req_key,
   input  wire logic [oaht_pkg::HASH_W-1:0]       req_hash,
   input  wire logic [oaht_pkg::VALUE_W-1:0]      req_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_ok,
   output logic      [oaht_pkg::VALUE_W-1:0]      rsp_found_value,
   output logic      [oaht_pkg::OCCUPIED_W-1:0]   rsp_occupied,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [oaht_pkg::SIZE_W-1:0]       csr_size_log2
);

   localparam int KEY_KEEP = (KEY_BITS < oaht_pkg::KEY_W) ? KEY_BITS : oaht_pkg::KEY_W;
   localparam int VAL_KEEP = (VALUE_BITS < oaht_pkg::VALUE_W) ? VALUE_BITS
                                                               : oaht_pkg::VALUE_W;
   localparam int HASH_W   = oaht_pkg::HASH_W;
   localparam int WORD_W   = oaht_pkg::STATUS_W + HASH_W + KEY_KEEP + VAL_KEEP;
   localparam int KEY_LSB  = VAL_KEEP;
   localparam int HASH_LSB = VAL_KEEP + KEY_KEEP;
   localparam int CNT_W    = SLOT_INDEX_BITS + 1;
   localparam int DEPTH    = 2 ** SLOT_INDEX_BITS;
   localparam logic [4:0] MAX_BITS = 5'(SLOT_INDEX_BITS);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PROBE = 4'b0010,
      ST_CLEAR = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                        state_ff, state_in;
   oaht_pkg::cmd_type                cmd_ff, cmd_in;
   logic [KEY_KEEP-1:0]              key_ff, key_in;
   logic [HASH_W-1:0]                hash_ff, hash_in;
   logic [VAL_KEEP-1:0]              value_ff, value_in;
   logic [SLOT_INDEX_BITS-1:0]       p_ff, p_in;
   logic [SLOT_INDEX_BITS-1:0]       i_ff, i_in;
   logic [SLOT_INDEX_BITS-1:0]       tomb_ff, tomb_in;
   logic                             have_tomb_ff, have_tomb_in;
   logic [SLOT_INDEX_BITS-1:0]       clr_ff, clr_in;
   logic                             boot_ff, boot_in;
   logic [CNT_W-1:0]                 count_ff, count_in;
   logic                             res_ok_ff, res_ok_in;
   logic [VAL_KEEP-1:0]              res_found_ff, res_found_in;
   logic [oaht_pkg::SIZE_W-1:0]      size_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             rsp_ok_ff;
   logic [oaht_pkg::VALUE_W-1:0]     rsp_found_ff;
   logic [oaht_pkg::OCCUPIED_W-1:0]  rsp_occ_ff;
   logic                             rsp_load;

   logic [4:0]                       act_bits;
   logic [SLOT_INDEX_BITS-1:0]       mask_w;
   logic [SLOT_INDEX_BITS-1:0]       home_w;
   logic [SLOT_INDEX_BITS-1:0]       p_next;

   logic                             ram_we;
   logic [SLOT_INDEX_BITS-1:0]       ram_waddr;
   logic [WORD_W-1:0]                ram_wdata;
   logic [SLOT_INDEX_BITS-1:0]       ram_raddr;
   logic [WORD_W-1:0]                ram_rdata;

   oaht_pkg::slot_status_type        rd_status;
   logic                             hit, free_hit, is_tomb;
   logic [WORD_W-1:0]                ins_word;
   logic [WORD_W-1:0]                del_word;
   logic [WORD_W-1:0]                clr_word;

   // Active slot mask, with the size register clamped to the legal range.
   always_comb begin
      if (size_ff == '0) begin
         act_bits = 5'd1;
      end else if ({1'b0, size_ff} > MAX_BITS) begin
         act_bits = MAX_BITS;
      end else begin
         act_bits = {1'b0, size_ff};
      end
      for (int b = 0; b < SLOT_INDEX_BITS; b++) begin
         mask_w[b] = (5'(b) < act_bits);
      end
   end

   assign home_w = req_hash[SLOT_INDEX_BITS-1:0] & mask_w;

   // Triangular offsets grow by i+1 each step, so one adder walks the sequence.
   assign p_next = SLOT_INDEX_BITS'(p_ff + i_ff + 1'b1) & mask_w;

   assign rd_status = oaht_pkg::slot_status_type'(ram_rdata[WORD_W-1 -: oaht_pkg::STATUS_W]);
   assign ins_word  = {oaht_pkg::SLOT_USED, hash_ff, key_ff, value_ff};
   assign del_word  = {oaht_pkg::SLOT_TOMB, ram_rdata[WORD_W-oaht_pkg::STATUS_W-1:0]};
   assign clr_word  = {oaht_pkg::SLOT_EMPTY, {(WORD_W-oaht_pkg::STATUS_W){1'b0}}};

   always_comb begin
      hit      = 1'b0;
      free_hit = 1'b0;
      is_tomb  = 1'b0;
      case (rd_status) inside
         oaht_pkg::SLOT_USED: begin
            hit = (ram_rdata[HASH_LSB +: HASH_W] == hash_ff) &&
                  (ram_rdata[KEY_LSB +: KEY_KEEP] == key_ff);
         end
         oaht_pkg::SLOT_EMPTY: begin
            free_hit = 1'b1;
         end
         default: begin
            is_tomb = 1'b1;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      hash_in      = hash_ff;
      value_in     = value_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      tomb_in      = tomb_ff;
      have_tomb_in = have_tomb_ff;
      clr_in       = clr_ff;
      boot_in      = boot_ff;
      count_in     = count_ff;
      res_ok_in    = res_ok_ff;
      res_found_in = res_found_ff;
      rsp_load     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = p_ff;
      ram_wdata    = ins_word;
      ram_raddr    = p_next;

      unique case (state_ff)
         ST_IDLE: begin
            ram_raddr = home_w;
            if (req_valid && req_ready) begin
               cmd_in       = oaht_pkg::cmd_type'(req_cmd);
               key_in       = req_key[KEY_KEEP-1:0];
               hash_in      = req_hash;
               value_in     = req_value[VAL_KEEP-1:0];
               res_ok_in    = 1'b0;
               res_found_in = '0;
               if (oaht_pkg::cmd_type'(req_cmd) == oaht_pkg::CMD_CLEAR) begin
                  clr_in   = '0;
                  boot_in  = 1'b0;
                  state_in = ST_CLEAR;
               end else begin
                  p_in         = home_w;
                  i_in         = '0;
                  have_tomb_in = 1'b0;
                  state_in     = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (hit) begin
               state_in = ST_DONE;
               if (cmd_ff == oaht_pkg::CMD_LOOKUP) begin
                  res_ok_in    = 1'b1;
                  res_found_in = ram_rdata[VAL_KEEP-1:0];
               end else if (cmd_ff == oaht_pkg::CMD_REMOVE) begin
                  res_ok_in = 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = p_ff;
                  ram_wdata = del_word;
                  if (count_ff != '0) begin
                     count_in = CNT_W'(count_ff - 1'b1);
                  end
               end
            end else if (free_hit) begin
               state_in = ST_DONE;
               if (cmd_ff == oaht_pkg::CMD_INSERT) begin
                  res_ok_in = 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = have_tomb_ff ? tomb_ff : p_ff;
                  count_in  = CNT_W'(count_ff + 1'b1);
               end
            end else if (i_ff == mask_w) begin
               // Last probe without a free slot: fall back on the first tombstone.
               state_in = ST_DONE;
               if ((cmd_ff == oaht_pkg::CMD_INSERT) && (have_tomb_ff || is_tomb)) begin
                  res_ok_in = 1'b1;
                  ram_we    = 1'b1;
                  ram_waddr = have_tomb_ff ? tomb_ff : p_ff;
                  count_in  = CNT_W'(count_ff + 1'b1);
               end
            end else begin
               p_in = p_next;
               i_in = SLOT_INDEX_BITS'(i_ff + 1'b1);
               if (is_tomb && !have_tomb_ff) begin
                  have_tomb_in = 1'b1;
                  tomb_in      = p_ff;
               end
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = clr_word;
            if (clr_ff == '1) begin
               count_in = '0;
               if (boot_ff) begin
                  boot_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  res_ok_in    = 1'b1;
                  res_found_in = '0;
                  state_in     = ST_DONE;
               end
            end else begin
               clr_in = SLOT_INDEX_BITS'(clr_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         boot_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         size_ff      <= oaht_pkg::SIZE_LOG2_RESET;
         have_tomb_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         boot_ff      <= boot_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         have_tomb_ff <= have_tomb_in;
         if (csr_valid && csr_ready) begin
            size_ff <= csr_size_log2;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      hash_ff      <= hash_in;
      value_ff     <= value_in;
      p_ff         <= p_in;
      i_ff         <= i_in;
      tomb_ff      <= tomb_in;
      res_ok_ff    <= res_ok_in;
      res_found_ff <= res_found_in;
      if (rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_found_ff <= oaht_pkg::VALUE_W'(res_found_ff);
         rsp_occ_ff   <= oaht_pkg::OCCUPIED_W'(count_ff);
      end
   end

   oaht_ram #(
      .WIDTH     (WORD_W),
      .ADDR_BITS (SLOT_INDEX_BITS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // A size write takes the idle cycle first, so a request always sees the
   // size it will be walked with.
   assign req_ready       = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_found_value = rsp_found_ff;
   assign rsp_occupied    = rsp_occ_ff;

   // The slot memory is only written by the probe walk or the clearing sweep.
   assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_PROBE) || (state_ff == ST_CLEAR)))
      else $error("slot memory written outside probe or clear");

   // The occupied count can never exceed the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupied count beyond table depth");

   // The probe step counter stays within the active capacity.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE) |-> (i_ff <= mask_w))
      else $error("probe step beyond capacity");

   // A successful insert adds exactly one to the occupied count.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_PROBE) && ram_we && (cmd_ff == oaht_pkg::CMD_INSERT))
      |=> (count_ff == CNT_W'($past(count_ff) + 1'b1)))
      else $error("insert did not count the new entry");

endmodule

`default_nettype wire

>>> rtl/core/oaht_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module oaht_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 4
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [2**ADDR_BITS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sim/oaht_response_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table response checker
// Watches the request, response and size register channels of the hash table
// core, keeps its own copy of the slot array and checks every response word
// against the answer worked out for the request that caused it.
// ----------------------------------------------------------------------------
module oaht_response_checker #(
   parameter int SLOT_INDEX_BITS = oaht_pkg::SLOT_INDEX_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_ready,
   input  wire logic [oaht_pkg::CMD_W-1:0]        req_cmd,
   input  wire logic [oaht_pkg::KEY_W-1:0]        req_key,
   input  wire logic [oaht_pkg::HASH_W-1:0]       req_hash,
   input  wire logic [oaht_pkg::VALUE_W-1:0]      req_value,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_ready,
   input  wire logic                              rsp_ok,
   input  wire logic [oaht_pkg::VALUE_W-1:0]      rsp_found_value,
   input  wire logic [oaht_pkg::OCCUPIED_W-1:0]   rsp_occupied,
   input  wire logic                              csr_valid,
   input  wire logic                              csr_ready,
   input  wire logic [oaht_pkg::SIZE_W-1:0]       csr_size_log2,
   output int unsigned                            error_count,
   output int unsigned                            pending_count
);

   localparam int SLOTS = 1 << SLOT_INDEX_BITS;

   typedef struct packed {
      logic                            ok;
      logic [oaht_pkg::VALUE_W-1:0]    found_value;
      logic [oaht_pkg::OCCUPIED_W-1:0] occupied;
   } answer_type;

   answer_type                      awaited_answers[$];
   oaht_pkg::slot_status_type       slot_state [SLOTS];
   logic [oaht_pkg::KEY_W-1:0]      slot_key   [SLOTS];
   logic [oaht_pkg::HASH_W-1:0]     slot_hash  [SLOTS];
   logic [oaht_pkg::VALUE_W-1:0]    slot_value [SLOTS];
   logic [oaht_pkg::OCCUPIED_W-1:0] used_slots;
   logic [oaht_pkg::SIZE_W-1:0]     size_log2;
   int unsigned                     errors;

   function automatic void store_entry(input int unsigned slot,
                                       input logic [oaht_pkg::KEY_W-1:0] key,
                                       input logic [oaht_pkg::HASH_W-1:0] hash,
                                       input logic [oaht_pkg::VALUE_W-1:0] value);
      slot_state[slot] = oaht_pkg::SLOT_USED;
      slot_key[slot]   = key;
      slot_hash[slot]  = hash;
      slot_value[slot] = value;
      used_slots       = used_slots + 1'b1;
   endfunction

   // Walks the triangular probe sequence exactly as the table does and
   // updates the slot copy on the way.
   function automatic answer_type apply_request(input oaht_pkg::cmd_type op,
                                                input logic [oaht_pkg::KEY_W-1:0] key,
                                                input logic [oaht_pkg::HASH_W-1:0] hash,
                                                input logic [oaht_pkg::VALUE_W-1:0] value);
      answer_type  ans;
      int unsigned bits;
      int unsigned mask;
      int unsigned home;
      int unsigned step;
      int unsigned p;
      int unsigned tomb;
      bit          have_tomb;
      bit          walk_over;
      ans       = '0;
      bits      = (size_log2 < 1) ? 1 :
                  (size_log2 > SLOT_INDEX_BITS) ? SLOT_INDEX_BITS : size_log2;
      mask      = (1 << bits) - 1;
      home      = hash[31:0] & mask;
      have_tomb = 1'b0;
      walk_over = 1'b0;
      tomb      = 0;
      if (op == oaht_pkg::CMD_CLEAR) begin
         for (int s = 0; s < SLOTS; s++) slot_state[s] = oaht_pkg::SLOT_EMPTY;
         used_slots = '0;
         ans.ok     = 1'b1;
      end else begin
         for (step = 0; step <= mask && !walk_over; step++) begin
            p = (home + (step + step * step) / 2) & mask;
            if (slot_state[p] == oaht_pkg::SLOT_USED) begin
               if (slot_hash[p] == hash && slot_key[p] == key) begin
                  walk_over = 1'b1;
                  if (op == oaht_pkg::CMD_LOOKUP) begin
                     ans.ok          = 1'b1;
                     ans.found_value = slot_value[p];
                  end else if (op == oaht_pkg::CMD_REMOVE) begin
                     slot_state[p] = oaht_pkg::SLOT_TOMB;
                     if (used_slots != 0) used_slots = used_slots - 1'b1;
                     ans.ok = 1'b1;
                  end
               end
            end else if (slot_state[p] == oaht_pkg::SLOT_EMPTY) begin
               walk_over = 1'b1;
               if (op == oaht_pkg::CMD_INSERT) begin
                  store_entry(have_tomb ? tomb : p, key, hash, value);
                  ans.ok = 1'b1;
               end
            end else if (!have_tomb) begin
               have_tomb = 1'b1;
               tomb      = p;
            end
         end
         // A walk with no free slot still lets an insert take a tombstone.
         if (!walk_over && op == oaht_pkg::CMD_INSERT && have_tomb) begin
            store_entry(tomb, key, hash, value);
            ans.ok = 1'b1;
         end
      end
      ans.occupied = used_slots;
      return ans;
   endfunction

   always @(posedge clock) begin : watch_channels
      answer_type want;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) slot_state[s] = oaht_pkg::SLOT_EMPTY;
         used_slots = '0;
         size_log2  = oaht_pkg::SIZE_LOG2_RESET;
         awaited_answers.delete();
      end else begin
         // Responses are compared before the request of this edge is added.
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               $display("%0t: unexpected response word: ok %0b found_value %h occupied %0d",
                        $time, rsp_ok, rsp_found_value, rsp_occupied);
               errors++;
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_ok !== want.ok) begin
                  $display("%0t: ok mismatch: expected %0b, actual %0b",
                           $time, want.ok, rsp_ok);
                  errors++;
               end
               if (rsp_found_value !== want.found_value) begin
                  $display("%0t: found_value mismatch: expected %h, actual %h",
                           $time, want.found_value, rsp_found_value);
                  errors++;
               end
               if (rsp_occupied !== want.occupied) begin
                  $display("%0t: occupied mismatch: expected %0d, actual %0d",
                           $time, want.occupied, rsp_occupied);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) size_log2 = csr_size_log2;
         if (req_valid && req_ready)
            awaited_answers.push_back(apply_request(oaht_pkg::cmd_type'(req_cmd), req_key,
                                                    req_hash, req_value));
      end
      error_count   <= errors;
      pending_count <= awaited_answers.size();
   end

endmodule

>>> sim/tb_open_address_hash_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open-address hash table core testbench
// Drives directed and random table requests through a range of table sizes,
// with random stalls on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_open_address_hash_table_core;

   localparam int SLOT_INDEX_BITS = oaht_pkg::SLOT_INDEX_BITS_DEFAULT;
   localparam int STALL_LIMIT     = 20000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int PHASE_COUNT     = 12;
   localparam int PHASE_WORDS     = 130;
   // Table sizes of the random phases, first phase in the low nibble.
   localparam logic [4*PHASE_COUNT-1:0] PHASE_SIZES =
      {4'd7, 4'd9, 4'd8, 4'd4, 4'd5, 4'd10, 4'd2, 4'd6, 4'd1, 4'd15, 4'd0, 4'd3};

   typedef struct {
      logic [oaht_pkg::KEY_W-1:0]  key;
      logic [oaht_pkg::HASH_W-1:0] hash;
   } key_entry_type;

   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_ready;
   oaht_pkg::cmd_type               req_cmd         = oaht_pkg::CMD_INSERT;
   logic [oaht_pkg::KEY_W-1:0]      req_key         = '0;
   logic [oaht_pkg::HASH_W-1:0]     req_hash        = '0;
   logic [oaht_pkg::VALUE_W-1:0]    req_value       = '0;
   logic                            rsp_valid;
   logic                            rsp_ready       = 1'b0;
   logic                            rsp_ok;
   logic [oaht_pkg::VALUE_W-1:0]    rsp_found_value;
   logic [oaht_pkg::OCCUPIED_W-1:0] rsp_occupied;
   logic                            csr_valid       = 1'b0;
   logic                            csr_ready;
   logic [oaht_pkg::SIZE_W-1:0]     csr_size_log2   = '0;
   int unsigned                     error_count;
   int unsigned                     pending_count;
   int unsigned                     idle_cycles     = 0;
   bit                              calm            = 1'b0;
   key_entry_type                   key_pool[$];

   always #5 clock = ~clock;

   open_address_hash_table_core #(
      .SLOT_INDEX_BITS(SLOT_INDEX_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_key(req_key), .req_hash(req_hash), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_found_value(rsp_found_value), .rsp_occupied(rsp_occupied),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_size_log2(csr_size_log2)
   );

   oaht_response_checker #(
      .SLOT_INDEX_BITS(SLOT_INDEX_BITS)
   ) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_key(req_key), .req_hash(req_hash), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_ok(rsp_ok),
      .rsp_found_value(rsp_found_value), .rsp_occupied(rsp_occupied),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_size_log2(csr_size_log2),
      .error_count(error_count), .pending_count(pending_count)
   );

   // The watchdog only counts cycles in which no word moves on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : response_pacing
      int unsigned n;
      @(posedge clock);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 19);
            rsp_ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         n = $urandom_range(1, 24);
         rsp_ready <= 1'b1;
         repeat (n) @(posedge clock);
      end
   end

   task automatic send_request(input oaht_pkg::cmd_type op,
                               input logic [oaht_pkg::KEY_W-1:0] key,
                               input logic [oaht_pkg::HASH_W-1:0] hash,
                               input logic [oaht_pkg::VALUE_W-1:0] value);
      int unsigned gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 19);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd   <= op;
      req_key   <= key;
      req_hash  <= hash;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_for_answers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_size(input logic [oaht_pkg::SIZE_W-1:0] size);
      wait_for_answers();
      csr_valid     <= 1'b1;
      csr_size_log2 <= size;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Three more keys than slots, but no more than 24, with about a third of them
   // crowded around one home slot so that probe chains get long.
   task automatic refill_pool(input int unsigned slots);
      key_entry_type e;
      int unsigned   count;
      int unsigned   crowd;
      count = (slots + 3 > 24) ? 24 : slots + 3;
      crowd = $urandom;
      key_pool.delete();
      repeat (count) begin
         e.key  = $urandom;
         e.hash = {$urandom, $urandom};
         if ($urandom_range(0, 2) == 0) e.hash[9:0] = 10'(crowd[9:0] + $urandom_range(0, 3));
         key_pool.push_back(e);
      end
   endtask

   task automatic send_random_request();
      key_entry_type     e;
      int unsigned       roll;
      oaht_pkg::cmd_type op;
      roll = $urandom_range(0, 99);
      if (roll < 2)       op = oaht_pkg::CMD_CLEAR;
      else if (roll < 42) op = oaht_pkg::CMD_INSERT;
      else if (roll < 72) op = oaht_pkg::CMD_LOOKUP;
      else                op = oaht_pkg::CMD_REMOVE;
      e    = key_pool[$urandom_range(0, key_pool.size() - 1)];
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
         e.hash ^= 64'd1 << $urandom_range(0, 63);
      end else if (roll < 10) begin
         e.key ^= 32'd1 << $urandom_range(0, 31);
      end else if (roll < 14) begin
         e.key  = $urandom;
         e.hash = {$urandom, $urandom};
      end
      send_request(op, e.key, e.hash, $urandom);
   endtask

   initial begin : stimulus
      logic [oaht_pkg::SIZE_W-1:0] size;
      int unsigned                 bits;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Full-size table after reset: duplicates, collisions and tombstones.
      send_request(oaht_pkg::CMD_INSERT, 32'h0000_0000, 64'h0, 32'hFFFF_FFFF);
      send_request(oaht_pkg::CMD_INSERT, 32'h0000_0000, 64'h0, 32'h1234_5678);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0000_0000, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   32'h0000_0000);
      send_request(oaht_pkg::CMD_INSERT, 32'h5A5A_5A5A, 64'h400, 32'hA5A5_A5A5);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0000_0000, 64'h1_0000_0000, $urandom);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0000_0001, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_REMOVE, 32'h0000_0000, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h5A5A_5A5A, 64'h400, $urandom);
      send_request(oaht_pkg::CMD_REMOVE, 32'h0000_0000, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_INSERT, 32'h0BAD_CAFE, 64'h800, 32'h0F0F_0F0F);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0BAD_CAFE, 64'h800, $urandom);
      send_request(oaht_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, $urandom);
      send_request(oaht_pkg::CMD_CLEAR, $urandom, {$urandom, $urandom}, $urandom);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h5A5A_5A5A, 64'h400, $urandom);

      // Two slots: a full table, and a tombstone taken after a walk with no
      // free slot.
      write_size(4'd1);
      send_request(oaht_pkg::CMD_INSERT, 32'h0000_00A0, 64'h0, 32'h0000_0001);
      send_request(oaht_pkg::CMD_INSERT, 32'h0000_00B0, 64'h1, 32'h0000_0002);
      send_request(oaht_pkg::CMD_INSERT, 32'h0000_00C0, 64'h0, 32'h0000_0003);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0000_00C0, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_REMOVE, 32'h0000_00A0, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_INSERT, 32'h0000_00C0, 64'h0, 32'h0000_0004);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0000_00C0, 64'h0, $urandom);
      send_request(oaht_pkg::CMD_REMOVE, 32'h0000_00B0, 64'h1, $urandom);
      send_request(oaht_pkg::CMD_LOOKUP, 32'h0000_00B0, 64'h1, $urandom);

      // Entries are carried over from one size to the next on purpose.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         size = PHASE_SIZES[4*phase +: 4];
         write_size(size);
         bits = (size < 1) ? 1 : (size > SLOT_INDEX_BITS) ? SLOT_INDEX_BITS : size;
         refill_pool(1 << bits);
         if (phase == PHASE_COUNT - 1) calm = 1'b1;
         repeat (PHASE_WORDS) send_random_request();
      end

      wait_for_answers();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
